### hdl/indexed_list_engine_defines.svh
// Assertion macros shared by the indexed list engine RTL.
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ILE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ILE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ilist_pkg.sv
// Types, codes and helpers shared by the indexed list engine.
package ilist_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int POS_W  = 11;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 11;
    // Wide enough for any list location or count up to the largest capacity.
    localparam int LOC_W  = 17;

    localparam logic [CMD_W-1:0] CMD_READ     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INS_AT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic [DATA_W-1:0] READ_MISS = {DATA_W{1'b1}};

    // Shift control broadcast to every cell.
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [LOC_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

    // Tree level d (root is 0) of a tree with lg levels is registered when
    // it is the root or sits a multiple of three levels above the leaves.
    function automatic bit tree_level_reg(int lg, int d);
        return (d == 0) || (((lg - d) % 3) == 0);
    endfunction

    function automatic int tree_regs(int lg);
        int n;
        n = 0;
        for (int d = 0; d < lg; d++) begin
            if (tree_level_reg(lg, d)) begin
                n++;
            end
        end
        return n;
    endfunction

endpackage

### hdl/ilist_if.sv
// Request and response channel interfaces of the indexed list engine.
interface ilist_req_if import ilist_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] item_value;

    modport source (output valid, command, position, item_value, input ready);
    modport sink   (input valid, command, position, item_value, output ready);
endinterface

interface ilist_rsp_if import ilist_pkg::*; ();
    logic              valid;
    logic              ready;
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;

    modport source (output valid, read_value, status, length, input ready);
    modport sink   (input valid, read_value, status, length, output ready);
endinterface

### hdl/ilist_cell.sv
// One list slot: holds an entry and shifts it toward either neighbor.
module ilist_cell import ilist_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_entry,
    output logic [DATA_W-1:0] o_tap
);

    localparam logic [LOC_W-1:0] HERE = LOC_W'(IDX);

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;

    always_comb begin
        priority if (i_ctl.ins && (HERE > i_ctl.pos)) begin
            n_entry = i_left;
        end else if (i_ctl.ins && (HERE == i_ctl.pos)) begin
            n_entry = i_ctl.value;
        end else if (i_ctl.del && (HERE >= i_ctl.pos)) begin
            n_entry = i_right;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    // Drive the entry into the read tree only when this slot is addressed.
    assign o_tap   = (HERE == i_ctl.pos) ? r_entry : '0;

endmodule

### hdl/ilist_tree.sv
// OR reduction tree over the cell taps, registered at the root and every third level above the leaves.
module ilist_tree import ilist_pkg::*; #(
    parameter int LG = 10
) (
    input  logic                           i_clk,
    input  logic [(1<<LG)-1:0][DATA_W-1:0] i_taps,
    output logic [DATA_W-1:0]              o_root
);

    localparam int N = 1 << LG;

    logic [DATA_W-1:0] node [1:2*N-1];

    for (genvar j = 0; j < N; j++) begin : g_leaf
        assign node[N+j] = i_taps[j];
    end

    for (genvar k = 1; k < N; k++) begin : g_node
        localparam int D = $clog2(k + 1) - 1;
        logic [DATA_W-1:0] sum;
        assign sum = node[2*k] | node[2*k+1];
        if (tree_level_reg(LG, D)) begin : g_reg
            logic [DATA_W-1:0] r_sum;
            always_ff @(posedge i_clk) begin
                r_sum <= sum;
            end
            assign node[k] = r_sum;
        end else begin : g_comb
            assign node[k] = sum;
        end
    end

    assign o_root = node[1];

endmodule

### hdl/indexed_list_engine.sv
// Indexed list engine: a row of shifting cells holds the list in order.
// Insert, delete and out-of-range requests go straight into the result register.
// A read in range waits in a read state for the registered OR tree over the cells
// (a register at the root and every third level, about log2(CAPACITY)/3 deep) to settle.
// One request is in flight at a time; a new one is taken as the result leaves.
// Reset empties the list (length zero) and clears control; entry contents are not cleared.
`include "indexed_list_engine_defines.svh"

module indexed_list_engine import ilist_pkg::*; #(
    parameter int CAPACITY = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ilist_req_if.sink   i_req,
    ilist_rsp_if.source o_rsp
);

    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LG       = $clog2(CAPACITY);
    localparam int LEAVES   = 1 << LG;
    localparam int READ_LAT = tree_regs(LG);
    localparam int WAIT_W   = $clog2(READ_LAT + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    localparam logic [LOC_W-1:0] CAP_LOC = LOC_W'(CAPACITY);

    logic              r_state;
    logic              n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [LOC_W-1:0]  r_pos;
    logic [WAIT_W-1:0] r_wait;
    logic [WAIT_W-1:0] n_wait;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [DATA_W-1:0] r_rd_val;
    logic [DATA_W-1:0] n_rd_val;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  n_len;

    logic              accept;
    logic [LOC_W-1:0]  cnt_loc;
    logic [LOC_W-1:0]  pos_loc;
    logic [LOC_W-1:0]  n_count_loc;
    logic              full;
    t_cell_ctl         ctl;
    logic [DATA_W-1:0] root;

    logic [DATA_W-1:0]              entry [CAPACITY];
    logic [LEAVES-1:0][DATA_W-1:0]  taps;

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;
    assign cnt_loc     = LOC_W'(r_count);
    assign pos_loc     = LOC_W'(i_req.position);
    assign full        = (cnt_loc == CAP_LOC);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_wait      = r_wait;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_rd_val    = r_rd_val;
        n_status    = r_status;
        ctl.ins     = 1'b0;
        ctl.del     = 1'b0;
        ctl.pos     = (r_state == S_READ) ? r_pos : pos_loc;
        ctl.value   = i_req.item_value;

        if (r_state == S_READ) begin
            if (r_wait == '0) begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_rd_val    = root;
                n_status    = ST_DONE;
            end else begin
                n_wait = r_wait - WAIT_W'(1);
            end
        end else if (accept) begin
            n_out_valid = 1'b1;
            n_rd_val    = '0;
            n_status    = ST_DONE;
            unique case (i_req.command)
                CMD_READ: begin
                    if (pos_loc < cnt_loc) begin
                        // Hold the result until the tree settles.
                        n_out_valid = 1'b0;
                        n_state     = S_READ;
                        n_wait      = WAIT_W'(READ_LAT - 1);
                    end else begin
                        n_rd_val = READ_MISS;
                        n_status = ST_RANGE;
                    end
                end
                CMD_INS_HEAD, CMD_INS_TAIL: begin
                    ctl.pos = (i_req.command == CMD_INS_HEAD) ? '0 : cnt_loc;
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        ctl.ins = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_INS_AT: begin
                    if (pos_loc > cnt_loc) begin
                        n_status = ST_RANGE;
                    end else if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        ctl.ins = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_DELETE: begin
                    if (pos_loc >= cnt_loc) begin
                        n_status = ST_RANGE;
                    end else begin
                        ctl.del = 1'b1;
                        n_count = r_count - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign n_count_loc = LOC_W'(n_count);
    assign n_len       = (r_state == S_IDLE && accept) ? n_count_loc[LEN_W-1:0] : r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos <= pos_loc;
        end
        r_rd_val <= n_rd_val;
        r_status <= n_status;
        r_len    <= n_len;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;
        if (i == 0) begin : g_first
            assign left = ctl.value;
        end else begin : g_mid_l
            assign left = entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right = entry[i];
        end else begin : g_mid_r
            assign right = entry[i+1];
        end
        ilist_cell #(
            .IDX(i)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_left (left),
            .i_right(right),
            .o_entry(entry[i]),
            .o_tap  (taps[i])
        );
    end

    for (genvar j = CAPACITY; j < LEAVES; j++) begin : g_pad
        assign taps[j] = '0;
    end

    ilist_tree #(
        .LG(LG)
    ) u_tree (
        .i_clk (i_clk),
        .i_taps(taps),
        .o_root(root)
    );

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_value = r_rd_val;
    assign o_rsp.status     = r_status;
    assign o_rsp.length     = r_len;

    `ILE_ASSERT_NOW(a_count_cap, 1'b1, LOC_W'(r_count) <= CAP_LOC, "list count above capacity")
    `ILE_ASSERT_NOW(a_read_no_out, r_state == S_READ, !r_out_valid, "result pending during read")
    `ILE_ASSERT_NEXT(a_ins_grow, ctl.ins, r_count == $past(r_count) + CNT_W'(1), "insert lost")
    `ILE_ASSERT_NEXT(a_del_shrink, ctl.del, r_count == $past(r_count) - CNT_W'(1), "delete lost")

endmodule
